[sv/icr_pkg.sv]
package icr_pkg;

    // Verdict codes carried on the result channel.
    typedef enum logic [1:0] {
        VERDICT_IGNORE = 2'd0,
        VERDICT_HOP    = 2'd1,
        VERDICT_DEST   = 2'd2
    } t_verdict;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_EXPECTED_ID  = 1'b0,
        CFG_EXPECTED_SEQ = 1'b1
    } t_cfg_reg;

    localparam int unsigned CFG_DATA_W = 16;

    // Packet field constants.
    localparam logic [7:0] PROTO_ICMP         = 8'd1;
    localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
    localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
    localparam logic [7:0] CODE_TTL_EXPIRED   = 8'd0;
    localparam int unsigned PROTO_BYTE_POS    = 9;
    localparam int unsigned MIN_IP_BYTES      = 10;
    localparam int unsigned MIN_ICMP_BYTES    = 8 + 4 + 4;
    localparam int unsigned ICMP_HDR_BYTES    = 8;

endpackage

[sv/icmp_reply_classifier.sv]
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+--------------------------------------
// input    | in        | i_in_valid / o_in_ready | i_data_byte, i_last_byte
// result   | out       | o_out_valid/i_out_ready | o_verdict, o_stamp_seconds,
//          |           |                         | o_stamp_microseconds
// config   | in        | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// One byte is taken per cycle, except while a last byte waits behind a stalled result.
// A byte sits in the input register while the per-packet state is updated, and the last
// byte of a packet then writes the result register, from which the verdict is shown.
// Reset is synchronous and active low; it empties both registers and clears the packet
// state and the expected identifier and sequence.
// A stalled result holds only the last byte of the next packet; other bytes keep flowing.
module icmp_reply_classifier
    import icr_pkg::*;
#(
    parameter int unsigned MAX_PACKET_BYTES = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_verdict,
    output logic [31:0]           o_stamp_seconds,
    output logic [31:0]           o_stamp_microseconds,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned PW = $clog2(MAX_PACKET_BYTES + 1);
    localparam int unsigned CW = (PW > 8) ? PW : 8;

    // Configuration registers.
    logic [15:0] r_expected_id;
    logic [15:0] r_expected_seq;

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // Per-packet state.
    logic [PW-1:0] r_pos,      n_pos;
    logic [5:0]    r_ohb,      n_ohb;
    logic          r_proto,    n_proto;
    logic [7:0]    r_type,     n_type;
    logic [7:0]    r_code,     n_code;
    logic [5:0]    r_ihb,      n_ihb;
    logic [15:0]   r_cap_id,   n_cap_id;
    logic [15:0]   r_cap_seq,  n_cap_seq;
    logic [31:0]   r_cap_sec,  n_cap_sec;
    logic [31:0]   r_cap_usec, n_cap_usec;

    // Result register.
    logic          r_out_valid;
    t_verdict      r_verdict;
    logic [31:0]   r_stamp_sec;
    logic [31:0]   r_stamp_usec;

    logic          out_free;
    logic          advance;
    t_verdict      n_verdict;
    logic [31:0]   n_stamp_sec;
    logic [31:0]   n_stamp_usec;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign o_in_ready = !r_in_valid || advance;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id  <= '0;
            r_expected_seq <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_EXPECTED_ID:  r_expected_id  <= i_cfg_data[15:0];
                CFG_EXPECTED_SEQ: r_expected_seq <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Input register: loads on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // Byte decode, packet state update and verdict for the byte in the input register.
    always_comb begin
        logic          take;
        logic [PW-1:0] rel;
        logic [PW-1:0] inner_start;
        logic [PW-1:0] q;
        logic          time_exc;
        logic          match;
        logic [CW-1:0] len;
        logic [CW-1:0] thr_icmp;
        logic [CW-1:0] thr_inner;

        n_pos      = r_pos;
        n_ohb      = r_ohb;
        n_proto    = r_proto;
        n_type     = r_type;
        n_code     = r_code;
        n_ihb      = r_ihb;
        n_cap_id   = r_cap_id;
        n_cap_seq  = r_cap_seq;
        n_cap_sec  = r_cap_sec;
        n_cap_usec = r_cap_usec;
        rel        = '0;
        q          = '0;
        inner_start = '0;

        take = r_pos < PW'(MAX_PACKET_BYTES);
        time_exc = (r_type == TYPE_TIME_EXCEEDED) && (r_code == CODE_TTL_EXPIRED);

        if (take) begin
            n_pos = r_pos + PW'(1);
            if (r_pos == '0) begin
                n_ohb = {r_in_byte[3:0], 2'b00};
            end
            if (r_pos == PW'(PROTO_BYTE_POS)) begin
                n_proto = (r_in_byte == PROTO_ICMP);
            end
            if (r_pos >= PW'(n_ohb)) begin
                rel = r_pos - PW'(n_ohb);
                if (rel == PW'(0)) begin
                    n_type = r_in_byte;
                end
                if (rel == PW'(1)) begin
                    n_code = r_in_byte;
                end
                if (rel >= PW'(4)) begin
                    if (time_exc) begin
                        // Quoted datagram: its header length, then the inner echo fields.
                        if (rel == PW'(ICMP_HDR_BYTES)) begin
                            n_ihb = {r_in_byte[3:0], 2'b00};
                        end
                        inner_start = PW'(ICMP_HDR_BYTES) + PW'(n_ihb);
                        if (rel >= inner_start) begin
                            q = rel - inner_start;
                            if (q == PW'(4) || q == PW'(5)) begin
                                n_cap_id = {r_cap_id[7:0], r_in_byte};
                            end else if (q == PW'(6) || q == PW'(7)) begin
                                n_cap_seq = {r_cap_seq[7:0], r_in_byte};
                            end
                        end
                    end else if (r_type == TYPE_ECHO_REPLY) begin
                        // Echo reply: identifier, sequence, then the send timestamp.
                        if (rel == PW'(4) || rel == PW'(5)) begin
                            n_cap_id = {r_cap_id[7:0], r_in_byte};
                        end else if (rel == PW'(6) || rel == PW'(7)) begin
                            n_cap_seq = {r_cap_seq[7:0], r_in_byte};
                        end else if (rel >= PW'(8) && rel <= PW'(11)) begin
                            n_cap_sec = {r_cap_sec[23:0], r_in_byte};
                        end else if (rel >= PW'(12) && rel <= PW'(15)) begin
                            n_cap_usec = {r_cap_usec[23:0], r_in_byte};
                        end
                    end
                end
            end
        end

        // Verdict on the state as it stands after this byte.
        match     = (n_cap_id == r_expected_id) && (n_cap_seq == r_expected_seq);
        len       = CW'(n_pos);
        thr_icmp  = CW'(n_ohb) + CW'(MIN_ICMP_BYTES);
        thr_inner = thr_icmp + CW'(n_ihb);
        n_verdict = VERDICT_IGNORE;
        if (n_proto && len >= CW'(MIN_IP_BYTES) && len >= thr_icmp) begin
            if ((n_type == TYPE_TIME_EXCEEDED) && (n_code == CODE_TTL_EXPIRED)) begin
                if (len >= thr_inner && match) begin
                    n_verdict = VERDICT_HOP;
                end
            end else if (n_type == TYPE_ECHO_REPLY && match) begin
                n_verdict = VERDICT_DEST;
            end
        end

        // Timestamps go out only with a destination verdict.
        n_stamp_sec  = (n_verdict == VERDICT_DEST) ? n_cap_sec : '0;
        n_stamp_usec = (n_verdict == VERDICT_DEST) ? n_cap_usec : '0;

        // The last byte closes the packet and clears its state.
        if (r_in_last) begin
            n_pos      = '0;
            n_ohb      = '0;
            n_proto    = 1'b0;
            n_type     = '0;
            n_code     = '0;
            n_ihb      = '0;
            n_cap_id   = '0;
            n_cap_seq  = '0;
            n_cap_sec  = '0;
            n_cap_usec = '0;
        end
    end

    // Packet state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_ohb      <= '0;
            r_proto    <= 1'b0;
            r_type     <= '0;
            r_code     <= '0;
            r_ihb      <= '0;
            r_cap_id   <= '0;
            r_cap_seq  <= '0;
            r_cap_sec  <= '0;
            r_cap_usec <= '0;
        end else if (advance) begin
            r_pos      <= n_pos;
            r_ohb      <= n_ohb;
            r_proto    <= n_proto;
            r_type     <= n_type;
            r_code     <= n_code;
            r_ihb      <= n_ihb;
            r_cap_id   <= n_cap_id;
            r_cap_seq  <= n_cap_seq;
            r_cap_sec  <= n_cap_sec;
            r_cap_usec <= n_cap_usec;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in_last) begin
            r_verdict    <= n_verdict;
            r_stamp_sec  <= n_stamp_sec;
            r_stamp_usec <= n_stamp_usec;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_verdict            = r_verdict;
    assign o_stamp_seconds      = r_stamp_sec;
    assign o_stamp_microseconds = r_stamp_usec;

endmodule

[sv/icr_checker.sv]
module icr_checker
    import icr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_verdict,
    input logic [31:0] o_stamp_seconds,
    input logic [31:0] o_stamp_microseconds
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_verdict) && $stable(o_stamp_seconds)
            && $stable(o_stamp_microseconds))
        else $error("result changed while stalled");

    // Only the three defined verdicts appear.
    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_verdict == VERDICT_IGNORE || o_verdict == VERDICT_HOP
                         || o_verdict == VERDICT_DEST))
        else $error("undefined verdict code");

    // Timestamps are zero unless the verdict is an echo reply match.
    a_stamp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_verdict != VERDICT_DEST |->
            o_stamp_seconds == '0 && o_stamp_microseconds == '0)
        else $error("timestamp without destination verdict");

    // The input stalls only behind a result that is waiting.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled with a free result register");

endmodule

bind icmp_reply_classifier icr_checker u_icr_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_in_ready           (o_in_ready),
    .o_out_valid          (o_out_valid),
    .i_out_ready          (i_out_ready),
    .o_verdict            (o_verdict),
    .o_stamp_seconds      (o_stamp_seconds),
    .o_stamp_microseconds (o_stamp_microseconds)
);
